[rtl/tlef_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tlef_pkg: shared types and constants for the text line ending filter
// Beat payload structs, character codes and register indexes.
// ----------------------------------------------------------------------------
package tlef_pkg;

  // Character codes that the filter treats specially.
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_SP = 8'h20;

  // Input beat function codes.
  localparam logic FUNC_DATA    = 1'b0;
  localparam logic FUNC_MAP_WR  = 1'b1;

  // Line end mode codes; bit 1 selects CR and bit 0 selects LF.
  localparam logic [1:0] MODE_PASS = 2'd0;
  localparam logic [1:0] MODE_LF   = 2'd1;
  localparam logic [1:0] MODE_CR   = 2'd2;
  localparam logic [1:0] MODE_CRLF = 2'd3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_END_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIP_SPACES  = 1'd1;

  // Field widths fixed by the beat formats.
  localparam int LEAD_W = 12;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic [7:0] map_index;
    logic [7:0] map_value;
  } in_item_t;

  typedef struct packed {
    logic [LEAD_W-1:0] lead_spaces;
    logic [1:0]        byte_count;
    logic [7:0]        first_byte;
    logic [7:0]        second_byte;
    logic              space_overflow;
  } out_item_t;

endpackage : tlef_pkg
`default_nettype wire

[rtl/tlef_char_map.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tlef_char_map: 256 x 8 character translation memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tlef_char_map (
  input  wire logic       clk,
  input  wire logic       wr_en,
  input  wire logic [7:0] wr_addr,
  input  wire logic [7:0] wr_data,
  input  wire logic       rd_en,
  input  wire logic [7:0] rd_addr,
  output logic      [7:0] rd_data
);

  logic [7:0] mem [256];
  logic [7:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule : tlef_char_map
`default_nettype wire

[rtl/text_line_ending_filter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// text_line_ending_filter: byte stream line ending and space filter
// Converts CR/LF to a chosen ending, strips trailing spaces and maps bytes.
// ----------------------------------------------------------------------------
// The filter takes one beat per clock cycle. Stage 1 reads the character
// map memory (registered read); stage 2 decides and loads the output
// register. Map write beats, held-back spaces and an LF swallowed after a
// converted CR give no result. A stall on the output
// holds the second stage and, through it, the input. The character map is not
// cleared by reset; load every entry in use with map write beats first.
// ----------------------------------------------------------------------------
module text_line_ending_filter #(
  parameter int MAX_PENDING_SPACES = 4095
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Input channel.
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire tlef_pkg::in_item_t               in_data,
  // Result channel.
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output tlef_pkg::out_item_t                   out_data,
  // Configuration port.
  input  wire logic                             cfg_we,
  input  wire logic [tlef_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tlef_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int PEND_W = $clog2(MAX_PENDING_SPACES + 1);
  localparam logic [PEND_W-1:0] PEND_MAX = PEND_W'(MAX_PENDING_SPACES);

  // Configuration registers.
  logic [1:0] line_end_mode_r;
  logic       strip_spaces_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_end_mode_r <= tlef_pkg::MODE_PASS;
      strip_spaces_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tlef_pkg::CFG_LINE_END_MODE: line_end_mode_r <= cfg_wdata[1:0];
        tlef_pkg::CFG_STRIP_SPACES:  strip_spaces_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Handshake: stage 1 moves on when the output register is free or drains.
  logic       in_acc;
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_go;

  assign s1_go    = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_acc   = in_valid && !in_stall;

  // Stage 1: map write or map read for a data beat.
  logic       is_data;
  logic [7:0] map_byte;

  assign is_data = (in_data.func == tlef_pkg::FUNC_DATA);

  tlef_char_map u_char_map (
    .clk     (clk),
    .wr_en   (in_acc && !is_data),
    .wr_addr (in_data.map_index),
    .wr_data (in_data.map_value),
    .rd_en   (in_acc && is_data),
    .rd_addr (in_data.data_byte),
    .rd_data (map_byte)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= is_data;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_data) begin
      s1_byte_r <= in_data.data_byte;
    end
  end

  // Filter state.
  logic [PEND_W-1:0] pending_r, pending_nxt;
  logic              skip_lf_r, skip_lf_nxt;
  logic              overflow_r, overflow_nxt;

  // Stage 2 decision.
  logic                  has_res;
  tlef_pkg::out_item_t   res;
  logic                  is_lf, is_cr, is_nl;
  logic [PEND_W-1:0]     pend_base;
  logic [31:0]           lead_ext;

  assign is_lf = (s1_byte_r == tlef_pkg::CH_LF);
  assign is_cr = (s1_byte_r == tlef_pkg::CH_CR);
  assign is_nl = is_lf || is_cr;
  // A line end in pass mode still discards the held spaces.
  assign pend_base = is_nl ? '0 : pending_r;
  assign lead_ext  = 32'(pend_base);

  always_comb begin
    has_res      = 1'b0;
    res          = '0;
    pending_nxt  = pending_r;
    skip_lf_nxt  = 1'b0;
    overflow_nxt = overflow_r;
    priority if (skip_lf_r && is_lf) begin
      // LF swallowed after a converted CR.
    end else if (is_nl && line_end_mode_r != tlef_pkg::MODE_PASS) begin
      has_res             = 1'b1;
      res.lead_spaces     = '0;
      res.byte_count      = 2'(line_end_mode_r[1]) + 2'(line_end_mode_r[0]);
      res.first_byte      = line_end_mode_r[1] ? tlef_pkg::CH_CR : tlef_pkg::CH_LF;
      res.second_byte     = (line_end_mode_r == tlef_pkg::MODE_CRLF) ?
                            tlef_pkg::CH_LF : 8'h00;
      res.space_overflow  = overflow_r;
      skip_lf_nxt         = is_cr;
      pending_nxt         = '0;
      overflow_nxt        = 1'b0;
    end else if (strip_spaces_r && s1_byte_r == tlef_pkg::CH_SP) begin
      // Hold the space back, saturating the count.
      if (pend_base < PEND_MAX) begin
        pending_nxt = pend_base + PEND_W'(1);
      end else begin
        pending_nxt  = pend_base;
        overflow_nxt = 1'b1;
      end
    end else begin
      has_res            = 1'b1;
      res.lead_spaces    = lead_ext[tlef_pkg::LEAD_W-1:0];
      res.byte_count     = 2'd1;
      res.first_byte     = map_byte;
      res.second_byte    = 8'h00;
      res.space_overflow = overflow_r;
      pending_nxt        = '0;
      overflow_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= '0;
      skip_lf_r  <= 1'b0;
      overflow_r <= 1'b0;
    end else if (s1_go) begin
      pending_r  <= pending_nxt;
      skip_lf_r  <= skip_lf_nxt;
      overflow_r <= overflow_nxt;
    end
  end

  // Output register.
  logic                out_valid_r;
  tlef_pkg::out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && has_res) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && has_res) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule : text_line_ending_filter
`default_nettype wire
